FILE: hdl/ppbc_pkg.sv
// shared types and constants for the ping-pong buffer controller
package ppbc_pkg;

  // fixed field widths of the channel payloads
  localparam int unsigned CMD_W        = 3;
  localparam int unsigned FIELD_LEN_W  = 16;
  localparam int unsigned CHOICE_W     = 2;
  localparam int unsigned LENGTH_BITS_DEF = 16;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_STOP    = 3'd0,
    CMD_RESTART = 3'd1,
    CMD_DRAIN   = 3'd2,
    CMD_FILL    = 3'd3,
    CMD_REPORT  = 3'd4
  } cmd_t;

  // buffer choice codes
  localparam logic [CHOICE_W-1:0] BUF_NONE   = 2'd0;
  localparam logic [CHOICE_W-1:0] BUF_FIRST  = 2'd1;
  localparam logic [CHOICE_W-1:0] BUF_SECOND = 2'd2;

  // buffer masks, bit 0 is the first buffer
  typedef logic [1:0] mask_t;
  localparam mask_t MASK_NONE = 2'b00;
  localparam mask_t MASK_A    = 2'b01;
  localparam mask_t MASK_B    = 2'b10;
  localparam mask_t MASK_BOTH = 2'b11;

endpackage

FILE: hdl/ppbc_if.sv
// valid/ready channel interfaces for commands and results
interface ppbc_cmd_if
  import ppbc_pkg::*;
  ();
  logic                   valid;
  logic                   ready;
  logic [CMD_W-1:0]       command;
  logic [FIELD_LEN_W-1:0] frame_length;
  logic                   frame_is_last;

  modport source (output valid, command, frame_length, frame_is_last, input ready);
  modport sink   (input valid, command, frame_length, frame_is_last, output ready);
endinterface

interface ppbc_res_if
  import ppbc_pkg::*;
  ();
  logic                   valid;
  logic                   ready;
  logic [CHOICE_W-1:0]    buffer_choice;
  logic [FIELD_LEN_W-1:0] out_length;
  logic                   out_last;
  logic                   request_fill;
  logic                   invariant_error;

  modport source (output valid, buffer_choice, out_length, out_last, request_fill,
                  invariant_error, input ready);
  modport sink   (input valid, buffer_choice, out_length, out_last, request_fill,
                  invariant_error, output ready);
endinterface

FILE: hdl/ping_pong_buffer_controller_top.sv
// Ping-pong double-buffer controller: takes one command beat per cycle and returns
// one result beat per command. A command is captured in an input register; when the
// output register is free it updates the buffer masks and flags and its result is
// written to the output register, where it is presented until accepted. Both
// registers advance together whenever the output register is empty or being read,
// so the block sustains one command per clock; only a stalled result channel slows
// it. Stored frame lengths keep LENGTH_BITS bits and are returned zero-extended.
module ping_pong_buffer_controller_top
  import ppbc_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  ppbc_cmd_if.sink   in_ch,
  ppbc_res_if.source out_ch
);

  // input register
  logic                   in_valid_r;
  logic [CMD_W-1:0]       in_cmd_r;
  logic [LENGTH_BITS-1:0] in_len_r;
  logic                   in_last_r;

  // controller state
  mask_t ready_mask_r,    ready_mask_nxt;
  mask_t stale_mask_r,    stale_mask_nxt;
  mask_t draining_mask_r, draining_mask_nxt;
  mask_t filling_mask_r,  filling_mask_nxt;
  logic  halted_r,        halted_nxt;
  logic  final_r,         final_nxt;
  logic [LENGTH_BITS-1:0] stored_len_r [2];
  logic                   stored_last_r [2];

  // output register
  logic                   out_valid_r;
  logic [CHOICE_W-1:0]    out_choice_r, out_choice_nxt;
  logic [FIELD_LEN_W-1:0] out_len_r,    out_len_nxt;
  logic                   out_last_r,   out_last_nxt;
  logic                   out_req_r,    out_req_nxt;
  logic                   out_err_r,    out_err_nxt;

  logic out_free;
  logic advance;
  logic store_en;
  logic store_idx;
  logic drain_idx;
  cmd_t cmd;

  // pipeline flow control
  assign out_free    = !out_valid_r || out_ch.ready;
  assign advance     = in_valid_r && out_free;
  assign in_ch.ready = !in_valid_r || out_free;
  assign cmd         = cmd_t'(in_cmd_r);
  assign drain_idx   = ready_mask_r[0] ? 1'b0 : 1'b1;
  assign store_idx   = filling_mask_r[0] ? 1'b0 : 1'b1;

  // command decode and state update
  always_comb begin
    ready_mask_nxt    = ready_mask_r;
    stale_mask_nxt    = stale_mask_r;
    draining_mask_nxt = draining_mask_r;
    filling_mask_nxt  = filling_mask_r;
    halted_nxt        = halted_r;
    final_nxt         = final_r;
    out_choice_nxt    = BUF_NONE;
    out_len_nxt       = '0;
    out_last_nxt      = 1'b0;
    out_req_nxt       = 1'b0;
    out_err_nxt       = 1'b0;
    store_en          = 1'b0;
    case (cmd)
      CMD_STOP: begin
        ready_mask_nxt   = MASK_NONE;
        filling_mask_nxt = MASK_NONE;
        stale_mask_nxt   = ~draining_mask_r;
        halted_nxt       = 1'b1;
      end
      CMD_RESTART: begin
        ready_mask_nxt   = MASK_NONE;
        filling_mask_nxt = MASK_NONE;
        stale_mask_nxt   = ~draining_mask_r;
        halted_nxt       = 1'b0;
        final_nxt        = 1'b0;
      end
      CMD_DRAIN: begin
        out_err_nxt    = (draining_mask_r == MASK_BOTH);
        stale_mask_nxt = stale_mask_r | draining_mask_r;
        if (final_r) begin
          out_last_nxt = 1'b1;
          final_nxt    = 1'b0;
          halted_nxt   = 1'b1;
        end else begin
          if (ready_mask_r == MASK_BOTH) begin
            out_err_nxt = 1'b1;
          end
          if (ready_mask_r == MASK_NONE) begin
            draining_mask_nxt = MASK_NONE;
          end else begin
            draining_mask_nxt = drain_idx ? MASK_B : MASK_A;
            ready_mask_nxt    = ready_mask_r & ~draining_mask_nxt;
            out_choice_nxt    = drain_idx ? BUF_SECOND : BUF_FIRST;
            out_len_nxt       = FIELD_LEN_W'(stored_len_r[drain_idx]);
            out_last_nxt      = stored_last_r[drain_idx];
            final_nxt         = stored_last_r[drain_idx];
          end
          out_req_nxt = !(final_nxt || halted_r || stale_mask_nxt == MASK_NONE);
        end
      end
      CMD_FILL: begin
        out_err_nxt = (draining_mask_r == MASK_BOTH);
        if (ready_mask_r == MASK_BOTH || filling_mask_r != MASK_NONE) begin
          out_choice_nxt = BUF_NONE;
        end else if (stale_mask_r[0]) begin
          stale_mask_nxt   = stale_mask_r & ~MASK_A;
          filling_mask_nxt = MASK_A;
          out_choice_nxt   = BUF_FIRST;
        end else if (stale_mask_r[1]) begin
          stale_mask_nxt   = stale_mask_r & ~MASK_B;
          filling_mask_nxt = MASK_B;
          out_choice_nxt   = BUF_SECOND;
        end
      end
      CMD_REPORT: begin
        if (filling_mask_r == MASK_NONE) begin
          out_err_nxt = 1'b1;
        end else begin
          out_err_nxt      = (filling_mask_r == MASK_BOTH);
          ready_mask_nxt   = ready_mask_r | filling_mask_r;
          filling_mask_nxt = MASK_NONE;
          store_en         = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
    if (in_ch.valid && in_ch.ready) begin
      in_cmd_r  <= in_ch.command;
      in_len_r  <= in_ch.frame_length[LENGTH_BITS-1:0];
      in_last_r <= in_ch.frame_is_last;
    end
  end

  // controller state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_mask_r    <= MASK_NONE;
      stale_mask_r    <= MASK_BOTH;
      draining_mask_r <= MASK_NONE;
      filling_mask_r  <= MASK_NONE;
      halted_r        <= 1'b1;
      final_r         <= 1'b0;
    end else if (advance) begin
      ready_mask_r    <= ready_mask_nxt;
      stale_mask_r    <= stale_mask_nxt;
      draining_mask_r <= draining_mask_nxt;
      filling_mask_r  <= filling_mask_nxt;
      halted_r        <= halted_nxt;
      final_r         <= final_nxt;
    end
  end

  // per-buffer frame length and last mark
  always_ff @(posedge clk) begin
    if (advance && store_en) begin
      stored_len_r[store_idx]  <= in_len_r;
      stored_last_r[store_idx] <= in_last_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= in_valid_r;
    end
    if (advance) begin
      out_choice_r <= out_choice_nxt;
      out_len_r    <= out_len_nxt;
      out_last_r   <= out_last_nxt;
      out_req_r    <= out_req_nxt;
      out_err_r    <= out_err_nxt;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.buffer_choice   = out_choice_r;
  assign out_ch.out_length      = out_len_r;
  assign out_ch.out_last        = out_last_r;
  assign out_ch.request_fill    = out_req_r;
  assign out_ch.invariant_error = out_err_r;

  // at most one buffer is ever being filled, and at most one is ever being drained
  a_masks_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(filling_mask_r) && $onehot0(draining_mask_r))
    else $error("filling or draining mask holds both buffers");

  // a fill request never comes with a final frame
  a_req_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_req_r |-> !out_last_r)
    else $error("fill requested together with last frame");

  // a length is returned only with a buffer choice
  a_len_has_choice: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_len_r != '0 |-> out_choice_r != BUF_NONE)
    else $error("length returned without a buffer");

  // result register updates only when the previous result was taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> out_valid_r && $stable(out_choice_r)
      && $stable(out_len_r))
    else $error("stalled result changed");

endmodule
